### src/sp_pkg.sv
// Shared types and constants of the stream prefetcher.
`default_nettype none
package sp_pkg;

   localparam int unsigned ADDR_W     = 64;
   localparam int unsigned PID_W      = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned DEGREE_W   = 5;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [DEGREE_W-1:0] MAX_OUT = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   localparam logic [1:0] ENTRY_INVALID    = 2'd0;
   localparam logic [1:0] ENTRY_TRAINING   = 2'd1;
   localparam logic [1:0] ENTRY_MONITORING = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREFETCH_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_LINES   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEGREE           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAINING_WINDOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAINING_THRESH  = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] access_address;
      logic [PID_W-1:0]  process_id;
      logic              cache_hit;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefetch_address;
      logic [PID_W-1:0]  prefetch_pid;
      logic              last_prefetch;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MONITOR,
      S_EMIT,
      S_COMMIT,
      S_TRAIN,
      S_ALLOC
   } state_type;

   typedef struct packed {
      logic capture;
      logic mon_eval;
      logic emit;
      logic mon_commit;
      logic train;
      logic alloc;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic hit;
      logic mon_match;
      logic deg_zero;
      logic emit_last;
      logic out_free;
      logic alloc_need;
      logic mon_found;
   } status_type;

endpackage
`default_nettype wire

### src/sp_ctrl.sv
// Controller state machine that sequences one request through the table.
`default_nettype none
module sp_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  sp_pkg::status_type  status,
   output sp_pkg::cmd_type     cmd
);

   sp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.enable) begin
                  state_in = sp_pkg::S_MONITOR;
               end
            end
         end
         sp_pkg::S_MONITOR: begin
            cmd.mon_eval = 1'b1;
            if (status.mon_match) begin
               state_in = status.deg_zero ? sp_pkg::S_COMMIT : sp_pkg::S_EMIT;
            end else begin
               state_in = status.hit ? sp_pkg::S_IDLE : sp_pkg::S_TRAIN;
            end
         end
         sp_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = sp_pkg::S_COMMIT;
               end
            end
         end
         sp_pkg::S_COMMIT: begin
            cmd.mon_commit = 1'b1;
            state_in = status.hit ? sp_pkg::S_IDLE : sp_pkg::S_TRAIN;
         end
         sp_pkg::S_TRAIN: begin
            cmd.train = 1'b1;
            state_in = status.alloc_need ? sp_pkg::S_ALLOC : sp_pkg::S_IDLE;
         end
         sp_pkg::S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = sp_pkg::S_IDLE;
         end
         default: begin
            state_in = sp_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### src/sp_datapath.sv
// Stream table, configuration registers, window compares and prefetch output register.
`default_nettype none
module sp_datapath #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned LINE_BYTES    = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  sp_pkg::req_type                      req_payload,
   input  wire                                  csr_write_enable,
   input  wire  [sp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [sp_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  sp_pkg::cmd_type                      cmd,
   output sp_pkg::status_type                   status,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output sp_pkg::rsp_type                      rsp_payload
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [63:0] LINE_MASK = ~(64'(LINE_BYTES) - 64'd1);
   localparam logic [63:0] LINE_STEP = 64'(LINE_BYTES);

   logic                       enable_ff;
   logic [7:0]                 distance_ff;
   logic [4:0]                 degree_ff;
   logic [7:0]                 twin_lines_ff;
   logic [7:0]                 thresh_ff;

   logic [1:0]                 status_ff [TABLE_ENTRIES];
   logic [1:0]                 status_in [TABLE_ENTRIES];
   logic                       asc_ff    [TABLE_ENTRIES];
   logic                       asc_in    [TABLE_ENTRIES];
   logic [7:0]                 count_ff  [TABLE_ENTRIES];
   logic [7:0]                 count_in  [TABLE_ENTRIES];
   logic [63:0]                pos_ff    [TABLE_ENTRIES];
   logic [63:0]                pos_in    [TABLE_ENTRIES];
   logic [63:0]                origin_ff [TABLE_ENTRIES];
   logic [63:0]                origin_in [TABLE_ENTRIES];
   logic [15:0]                pid_ff    [TABLE_ENTRIES];
   logic [15:0]                pid_in    [TABLE_ENTRIES];
   logic [IDX_W-1:0]           rank_ff   [TABLE_ENTRIES];
   logic [IDX_W-1:0]           rank_in   [TABLE_ENTRIES];

   logic [63:0]                addr_ff;
   logic [15:0]                rpid_ff;
   logic                       hit_ff;
   logic                       mon_found_ff;
   logic [IDX_W-1:0]           midx_ff;
   logic                       mon_asc_ff;
   logic [63:0]                work_pos_ff;
   logic [4:0]                 remain_ff;
   logic                       rsp_valid_ff;
   sp_pkg::rsp_type            rsp_ff;

   logic [63:0]                dist_bytes;
   logic [63:0]                twin;
   logic [4:0]                 deg_sat;
   logic                       mon_hit   [TABLE_ENTRIES];
   logic                       tr_match  [TABLE_ENTRIES];
   logic                       tr_dir    [TABLE_ENTRIES];
   logic                       tr_agree  [TABLE_ENTRIES];
   logic                       tr_flip   [TABLE_ENTRIES];
   logic                       mon_match;
   logic [IDX_W-1:0]           mon_idx;
   logic                       tr_found;
   logic [IDX_W-1:0]           tr_idx;
   logic                       seen;
   logic [IDX_W-1:0]           victim;
   logic [IDX_W-1:0]           touch_idx;
   logic [IDX_W-1:0]           touch_rank;
   logic                       do_touch;
   logic [7:0]                 tr_count_new;
   logic [7:0]                 mon_count;

   assign dist_bytes = 64'(distance_ff) * LINE_STEP;
   assign twin       = 64'(twin_lines_ff) * LINE_STEP;
   assign deg_sat    = (degree_ff > sp_pkg::MAX_OUT) ? sp_pkg::MAX_OUT : degree_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         distance_ff   <= 8'd16;
         degree_ff     <= 5'd1;
         twin_lines_ff <= 8'd16;
         thresh_ff     <= 8'd2;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sp_pkg::CSR_PREFETCH_ENABLE: enable_ff     <= csr_write_data[0];
            sp_pkg::CSR_DISTANCE_LINES:  distance_ff   <= csr_write_data;
            sp_pkg::CSR_DEGREE:          degree_ff     <= csr_write_data[4:0];
            sp_pkg::CSR_TRAINING_WINDOW: twin_lines_ff <= csr_write_data;
            sp_pkg::CSR_TRAINING_THRESH: thresh_ff     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         logic asc_w;
         logic desc_w;
         mon_hit[i] = (status_ff[i] == sp_pkg::ENTRY_MONITORING) && (pid_ff[i] == rpid_ff) &&
                      (asc_ff[i] ? (pos_ff[i] <= addr_ff && addr_ff < pos_ff[i] + dist_bytes)
                                 : (pos_ff[i] - dist_bytes <= addr_ff && addr_ff < pos_ff[i]));
         asc_w  = origin_ff[i] <= addr_ff && addr_ff < origin_ff[i] + twin;
         desc_w = origin_ff[i] - twin <= addr_ff && addr_ff < origin_ff[i];
         tr_match[i] = (status_ff[i] == sp_pkg::ENTRY_TRAINING) && (pid_ff[i] == rpid_ff) &&
                       (asc_w || desc_w);
         tr_dir[i]   = asc_w;
         tr_agree[i] = (count_ff[i] == 8'd0) || (asc_ff[i] == asc_w);
      end
   end

   always_comb begin
      mon_match = 1'b0;
      mon_idx   = '0;
      tr_found  = 1'b0;
      tr_idx    = '0;
      victim    = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (mon_hit[i]) begin
            mon_match = 1'b1;
            mon_idx   = IDX_W'(i);
         end
         if (tr_match[i] && tr_agree[i]) begin
            tr_found = 1'b1;
            tr_idx   = IDX_W'(i);
         end
         if (rank_ff[i] == '0) begin
            victim = IDX_W'(i);
         end
      end
      seen = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tr_flip[i] = tr_match[i] && !tr_agree[i] && !seen;
         seen       = seen || (tr_match[i] && tr_agree[i]);
      end
   end

   assign tr_count_new = (count_ff[tr_idx] == sp_pkg::COUNT_MAX) ? sp_pkg::COUNT_MAX
                                                                : count_ff[tr_idx] + 8'd1;
   assign mon_count    = (count_ff[midx_ff] == sp_pkg::COUNT_MAX) ? sp_pkg::COUNT_MAX
                                                                 : count_ff[midx_ff] + 8'd1;

   always_comb begin
      touch_idx = victim;
      do_touch  = 1'b0;
      if (cmd.mon_commit) begin
         touch_idx = midx_ff;
         do_touch  = 1'b1;
      end else if (cmd.train) begin
         touch_idx = tr_idx;
         do_touch  = tr_found;
      end else if (cmd.alloc) begin
         do_touch  = 1'b1;
      end
      touch_rank = rank_ff[touch_idx];

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         status_in[i] = status_ff[i];
         asc_in[i]    = asc_ff[i];
         count_in[i]  = count_ff[i];
         pos_in[i]    = pos_ff[i];
         origin_in[i] = origin_ff[i];
         pid_in[i]    = pid_ff[i];
         rank_in[i]   = rank_ff[i];
         if (do_touch && rank_ff[i] > touch_rank) begin
            rank_in[i] = rank_ff[i] - IDX_W'(1);
         end
         if (cmd.train && tr_flip[i]) begin
            asc_in[i]   = tr_dir[i];
            count_in[i] = 8'd0;
         end
      end

      if (do_touch) begin
         rank_in[touch_idx] = RANK_TOP;
      end
      if (cmd.mon_commit) begin
         pos_in[midx_ff]   = work_pos_ff;
         count_in[midx_ff] = mon_count;
      end
      if (cmd.train && tr_found) begin
         asc_in[tr_idx]   = tr_dir[tr_idx];
         count_in[tr_idx] = tr_count_new;
         if (tr_count_new >= thresh_ff) begin
            status_in[tr_idx] = sp_pkg::ENTRY_MONITORING;
         end
      end
      if (cmd.alloc) begin
         status_in[victim] = sp_pkg::ENTRY_TRAINING;
         asc_in[victim]    = 1'b0;
         count_in[victim]  = 8'd0;
         pos_in[victim]    = addr_ff;
         origin_in[victim] = addr_ff;
         pid_in[victim]    = rpid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (reset) begin
            status_ff[i] <= sp_pkg::ENTRY_INVALID;
            rank_ff[i]   <= IDX_W'(i);
         end else begin
            status_ff[i] <= status_in[i];
            rank_ff[i]   <= rank_in[i];
         end
         asc_ff[i]    <= asc_in[i];
         count_ff[i]  <= count_in[i];
         pos_ff[i]    <= pos_in[i];
         origin_ff[i] <= origin_in[i];
         pid_ff[i]    <= pid_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= req_payload.access_address & LINE_MASK;
         rpid_ff <= req_payload.process_id;
         hit_ff  <= req_payload.cache_hit;
      end
      if (cmd.mon_eval) begin
         midx_ff     <= mon_idx;
         mon_asc_ff  <= asc_ff[mon_idx];
         work_pos_ff <= pos_ff[mon_idx];
         remain_ff   <= deg_sat;
      end
      if (cmd.emit) begin
         rsp_ff.prefetch_address <= mon_asc_ff ? work_pos_ff + dist_bytes
                                               : work_pos_ff - dist_bytes;
         rsp_ff.prefetch_pid     <= rpid_ff;
         rsp_ff.last_prefetch    <= (remain_ff == 5'd1);
         work_pos_ff <= mon_asc_ff ? work_pos_ff + LINE_STEP : work_pos_ff - LINE_STEP;
         remain_ff   <= remain_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mon_found_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.mon_eval) begin
            mon_found_ff <= mon_match;
         end
      end
   end

   assign status.enable     = enable_ff;
   assign status.hit        = hit_ff;
   assign status.mon_match  = mon_match;
   assign status.deg_zero   = (deg_sat == 5'd0);
   assign status.emit_last  = (remain_ff == 5'd1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.alloc_need = !mon_found_ff && !tr_found;
   assign status.mon_found  = mon_found_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

### src/stream_prefetcher.sv
// Top level of the stream prefetcher: controller, datapath and checks.
`default_nettype none
// The block takes one request at a time and stalls its input until that request is done.
// A request dropped while prefetching is disabled is only captured; others are checked
// against the monitoring streams. A hit with degree d sends up to d prefetches out of the
// output register, one per cycle while it is not stalled. A miss adds a training step and,
// when it allocates an entry, an allocation step. LINE_BYTES must be a power of two.
module stream_prefetcher #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned LINE_BYTES    = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  sp_pkg::req_type                  req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output sp_pkg::rsp_type                  rsp_payload,
   input  wire                              csr_write_enable,
   input  wire  [sp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [sp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   sp_pkg::cmd_type    cmd;
   sp_pkg::status_type status;

   sp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sp_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .LINE_BYTES    (LINE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mon_eval, cmd.emit, cmd.mon_commit, cmd.train, cmd.alloc}))
      else $error("more than one datapath command active");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !(cmd.emit || cmd.mon_commit || cmd.train || cmd.alloc))
      else $error("table command issued while accepting a request");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("prefetch emitted over a pending one");
   a_alloc_nohit: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !status.mon_found)
      else $error("allocation after a monitor hit");
`endif

endmodule
`default_nettype wire
